>>> hw/rtl/aspd_pkg.sv
package aspd_pkg;

  // shared arithmetic unit widths
  localparam int DATA_W = 64;
  localparam int OPB_W  = 16;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam int DEFAULT_ENCODER_BITS = 12;
  localparam int DEFAULT_FRAC_BITS    = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // off phase reload, 0xA04B + 4 * 0x17ED folded to 16 bits
  localparam logic [15:0] OFF_RELOAD = 16'hFFFF;

  localparam logic [8:0]  RST_TARGET    = 9'd0;
  localparam logic [13:0] RST_GAIN      = 14'd100;
  localparam logic [9:0]  RST_RATE_LIM  = 10'd200;
  localparam logic [6:0]  RST_ACCEL_SC  = 7'd2;
  localparam logic [13:0] RST_PULSE_LIM = 14'd6125;
  localparam logic [13:0] RST_DEADBAND  = 14'd512;

  typedef enum logic [2:0] {
    REG_TARGET    = 3'd0,
    REG_GAIN      = 3'd1,
    REG_RATE_LIM  = 3'd2,
    REG_ACCEL_SC  = 3'd3,
    REG_PULSE_LIM = 3'd4,
    REG_DEADBAND  = 3'd5
  } cfg_reg_t;

  // drive direction codes of the result word
  typedef enum logic [1:0] {
    DIR_OFF = 2'd0,
    DIR_POS = 2'd1,
    DIR_NEG = 2'd2
  } drive_dir_t;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEG,
    S_AMUL,
    S_ADIV,
    S_VMUL,
    S_VDIV,
    S_UMUL,
    S_UDIV,
    S_EWDIV,
    S_EWMUL,
    S_RTMUL,
    S_ATMUL1,
    S_ATMUL2,
    S_ATDIV,
    S_P1MUL,
    S_P1DIV,
    S_P2MUL,
    S_P2DIV,
    S_P3MUL,
    S_P3DIV,
    S_OUT
  } state_t;

endpackage

>>> hw/rtl/aspd_alu.sv
module aspd_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  aspd_pkg::alu_req_t                  req,
  input  logic signed [aspd_pkg::DATA_W-1:0]  a,
  input  logic        [aspd_pkg::OPB_W-1:0]   b,
  output logic                                done,
  output logic signed [aspd_pkg::DATA_W-1:0]  res
);
  import aspd_pkg::*;

  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(OPB_W - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DATA_W - 1);

  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  alu_op_t                 op_r, op_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [DATA_W-1:0]       acc_r, acc_nxt;
  logic [DATA_W-1:0]       sh_r, sh_nxt;
  logic [OPB_W-1:0]        bsh_r, bsh_nxt;
  logic [OPB_W-1:0]        rem_r, rem_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;

  logic [OPB_W:0]          trial;
  logic                    qbit;
  logic [DATA_W-1:0]       mul_sum;
  logic [DATA_W-1:0]       quo;

  always_comb begin
    trial   = {rem_r, acc_r[DATA_W-1]};
    qbit    = (trial >= {1'b0, bsh_r});
    mul_sum = acc_r + (bsh_r[0] ? sh_r : '0);
    quo     = {acc_r[DATA_W-2:0], qbit};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    bsh_nxt  = bsh_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;

    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = '0;
      bsh_nxt  = b;
      rem_nxt  = '0;
      sh_nxt   = a;
      neg_nxt  = a[DATA_W-1];
      if (req.op == OP_MUL) begin
        acc_nxt = '0;
      end else begin
        acc_nxt = a[DATA_W-1] ? DATA_W'(-a) : DATA_W'(a);
      end
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (op_r == OP_MUL) begin
        // shift-add, one multiplier bit a cycle
        acc_nxt = mul_sum;
        sh_nxt  = {sh_r[DATA_W-2:0], 1'b0};
        bsh_nxt = {1'b0, bsh_r[OPB_W-1:1]};
        if (cnt_r == MUL_LAST) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = signed'(mul_sum);
        end
      end else begin
        // restoring divide on magnitudes, one quotient bit a cycle
        acc_nxt = quo;
        rem_nxt = qbit ? OPB_W'(trial - {1'b0, bsh_r}) : trial[OPB_W-1:0];
        if (cnt_r == DIV_LAST) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          res_nxt  = neg_r ? -signed'(quo) : signed'(quo);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
    bsh_r <= bsh_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

>>> hw/rtl/antenna_servo_pulse_drive_unit.sv
// Antenna servo pulse drive. Each accepted word is one timer tick carrying an
// absolute encoder reading, and each tick gives exactly one result word. A
// drive tick that drives is followed by an off tick, one inside the deadband
// by another drive tick; an off tick reports drive off with the fixed off
// reload and the held filtered angle. A drive tick runs the angle, rate and
// acceleration filters, the rate target and the pulse sum through one shared
// unit (a shift-add multiplier and a restoring divider) under a small
// sequencer: nine multiplies and eight divides, and one more of each when the
// target error has to be wrapped to +-180 degrees. The input is not ready
// while a tick is in progress. All angles are signed fixed point with
// FRAC_BITS fraction bits. Configuration may be written at any time the
// block is idle and is always taken at once.
module antenna_servo_pulse_drive_unit #(
  parameter int ENCODER_BITS = aspd_pkg::DEFAULT_ENCODER_BITS,
  parameter int FRAC_BITS    = aspd_pkg::DEFAULT_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ENCODER_BITS-1:0]             in_encoder_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_drive_direction,
  output logic [15:0]                         out_timer_reload,
  output logic signed [14:0]                  out_pulse_command,
  output logic signed [31:0]                  out_filtered_angle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aspd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aspd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import aspd_pkg::*;

  // fixed point constants
  localparam logic signed [63:0] FX90  = 64'sd90 <<< FRAC_BITS;
  localparam logic signed [63:0] FX180 = 64'sd180 <<< FRAC_BITS;
  localparam logic signed [63:0] FX270 = 64'sd270 <<< FRAC_BITS;
  localparam logic signed [63:0] FX360 = 64'sd360 <<< FRAC_BITS;
  localparam logic [63:0]        MAXPOS   = (64'd1 << ENCODER_BITS) - 64'd1;
  localparam logic signed [63:0] HALF_POS = signed'(MAXPOS >> 1);
  localparam logic signed [63:0] S32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN  = -64'sd2147483648;

  function automatic logic signed [63:0] seam(input logic signed [63:0] to_v,
                                              input logic signed [63:0] from_v);
    // shorter way across the 0/360 seam
    if (from_v > FX270 && to_v < FX90) begin
      seam = to_v + FX360 - from_v;
    end else if (to_v > FX270 && from_v < FX90) begin
      seam = to_v - from_v - FX360;
    end else begin
      seam = to_v - from_v;
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // sequencer and shared unit
  state_t                  state_r, state_nxt;
  logic                    issued_r, issued_nxt;
  alu_req_t                alu_req;
  logic signed [63:0]      alu_a;
  logic [OPB_W-1:0]        alu_b;
  logic                    alu_done;
  logic signed [63:0]      alu_res;

  // configuration
  logic [8:0]              tgt_r;
  logic [13:0]             gain_r;
  logic [9:0]              vl_r;
  logic [6:0]              us_r;
  logic [13:0]             plim_r;
  logic [13:0]             db_r;

  // filter state
  logic signed [31:0]      af_r, af_nxt;
  logic signed [31:0]      ap_r, ap_nxt;
  logic signed [31:0]      v_r, v_nxt;
  logic signed [31:0]      rp_r, rp_nxt;
  logic signed [31:0]      u_r, u_nxt;
  logic signed [31:0]      rtp_r, rtp_nxt;
  logic signed [31:0]      at_r, at_nxt;
  logic                    phase_r, phase_nxt;

  // working registers
  logic [ENCODER_BITS-1:0] pos_r, pos_nxt;
  logic                    off_r, off_nxt;
  logic                    wneg_r, wneg_nxt;
  logic signed [63:0]      t_r, t_nxt;
  logic signed [63:0]      x_r, x_nxt;
  logic signed [63:0]      rt_r, rt_nxt;

  // result word
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              dir_r, dir_nxt;
  logic [15:0]             reload_r, reload_nxt;
  logic signed [14:0]      pcmd_r, pcmd_nxt;
  logic signed [31:0]      angle_r, angle_nxt;

  // derived values
  logic signed [63:0]      af64, ap64, v64, rp64, u64, rtp64, at64;
  logic signed [63:0]      tgt_fx, vl_fx, plim_fx, db_fx;
  logic [9:0]              vl_eff;
  logic [6:0]              us_eff;
  logic signed [63:0]      err_now, ew_num;
  logic                    wrap_hi, wrap_lo;
  logic signed [63:0]      a_fix, sum, pabs, mag64;
  logic                    out_fire;

  assign af64  = 64'(af_r);
  assign ap64  = 64'(ap_r);
  assign v64   = 64'(v_r);
  assign rp64  = 64'(rp_r);
  assign u64   = 64'(u_r);
  assign rtp64 = 64'(rtp_r);
  assign at64  = 64'(at_r);

  // a zero normaliser counts as one
  assign vl_eff  = (vl_r == '0) ? 10'd1 : vl_r;
  assign us_eff  = (us_r == '0) ? 7'd1 : us_r;
  assign tgt_fx  = signed'(64'(tgt_r)) <<< FRAC_BITS;
  assign vl_fx   = signed'(64'(vl_eff)) <<< FRAC_BITS;
  assign plim_fx = signed'(64'(plim_r)) <<< FRAC_BITS;
  assign db_fx   = signed'(64'(db_r)) <<< FRAC_BITS;

  assign err_now = tgt_fx - af64;
  assign wrap_hi = (err_now > FX180);
  assign wrap_lo = (err_now < -FX180);
  assign ew_num  = wneg_r ? ((-FX180 - x_r + FX360 - 64'sd1) >>> FRAC_BITS)
                          : ((x_r - FX180 + FX360 - 64'sd1) >>> FRAC_BITS);

  assign in_ready  = (state_r == S_IDLE);
  // registers only change between ticks
  assign cfg_ready = (state_r == S_IDLE);
  assign out_fire  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  aspd_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = phase_r ? S_OUT : S_DEG;
      S_DEG:    if (alu_done) state_nxt = S_AMUL;
      S_AMUL:   if (alu_done) state_nxt = S_ADIV;
      S_ADIV:   if (alu_done) state_nxt = S_VMUL;
      S_VMUL:   if (alu_done) state_nxt = S_VDIV;
      S_VDIV:   if (alu_done) state_nxt = S_UMUL;
      S_UMUL:   if (alu_done) state_nxt = S_UDIV;
      S_UDIV:   if (alu_done) state_nxt = (wrap_hi || wrap_lo) ? S_EWDIV : S_RTMUL;
      S_EWDIV:  if (alu_done) state_nxt = S_EWMUL;
      S_EWMUL:  if (alu_done) state_nxt = S_RTMUL;
      S_RTMUL:  if (alu_done) state_nxt = S_ATMUL1;
      S_ATMUL1: if (alu_done) state_nxt = S_ATMUL2;
      S_ATMUL2: if (alu_done) state_nxt = S_ATDIV;
      S_ATDIV:  if (alu_done) state_nxt = S_P1MUL;
      S_P1MUL:  if (alu_done) state_nxt = S_P1DIV;
      S_P1DIV:  if (alu_done) state_nxt = S_P2MUL;
      S_P2MUL:  if (alu_done) state_nxt = S_P2DIV;
      S_P2DIV:  if (alu_done) state_nxt = S_P3MUL;
      S_P3MUL:  if (alu_done) state_nxt = S_P3DIV;
      S_P3DIV:  if (alu_done) state_nxt = S_OUT;
      S_OUT:    if (out_fire) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // operand selection for the shared unit, one start per step
  always_comb begin
    alu_req.start = (state_r != S_IDLE) && (state_r != S_OUT) && !issued_r;
    alu_req.op    = OP_MUL;
    alu_a         = '0;
    alu_b         = '0;
    case (state_r)
      S_DEG: begin
        alu_req.op = OP_DIV;
        alu_a      = signed'((64'(pos_r) * 64'd360) << FRAC_BITS) + HALF_POS;
        alu_b      = MAXPOS[OPB_W-1:0];
      end
      S_AMUL: begin
        alu_a = seam(t_r, af64);
        alu_b = OPB_W'(gain_r);
      end
      S_VMUL: begin
        alu_a = seam(af64, ap64) - v64;
        alu_b = OPB_W'(gain_r);
      end
      S_UMUL: begin
        alu_a = (v64 - rp64) - u64;
        alu_b = OPB_W'(gain_r);
      end
      S_ADIV, S_VDIV, S_UDIV, S_ATDIV: begin
        alu_req.op = OP_DIV;
        alu_a      = t_r;
        alu_b      = OPB_W'(100);
      end
      S_EWDIV: begin
        alu_req.op = OP_DIV;
        alu_a      = ew_num;
        alu_b      = OPB_W'(360);
      end
      S_EWMUL: begin
        alu_a = t_r;
        alu_b = OPB_W'(360);
      end
      S_RTMUL: begin
        alu_a = x_r;
        alu_b = OPB_W'(50);
      end
      S_ATMUL1: begin
        alu_a = rt_r - rtp64;
        alu_b = OPB_W'(1000);
      end
      S_ATMUL2: begin
        alu_a = t_r;
        alu_b = OPB_W'(gain_r);
      end
      S_P1MUL: begin
        alu_a = at64 - u64;
        alu_b = OPB_W'(plim_r);
      end
      S_P1DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = t_r;
        alu_b      = OPB_W'(us_eff);
      end
      S_P2MUL: begin
        alu_a = rt_r - v64;
        alu_b = OPB_W'(plim_r);
      end
      S_P2DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = t_r;
        alu_b      = OPB_W'({vl_eff, 1'b0});
      end
      S_P3MUL: begin
        alu_a = tgt_fx - af64;
        alu_b = OPB_W'(plim_r);
      end
      S_P3DIV: begin
        alu_req.op = OP_DIV;
        alu_a      = t_r;
        alu_b      = OPB_W'(1800);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  // datapath updates
  always_comb begin
    issued_nxt    = alu_done ? 1'b0 : (alu_req.start ? 1'b1 : issued_r);
    af_nxt        = af_r;
    ap_nxt        = ap_r;
    v_nxt         = v_r;
    rp_nxt        = rp_r;
    u_nxt         = u_r;
    rtp_nxt       = rtp_r;
    at_nxt        = at_r;
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    off_nxt       = off_r;
    wneg_nxt      = wneg_r;
    t_nxt         = t_r;
    x_nxt         = x_r;
    rt_nxt        = rt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    dir_nxt       = dir_r;
    reload_nxt    = reload_r;
    pcmd_nxt      = pcmd_r;
    angle_nxt     = angle_r;

    // angle update with one seam correction
    a_fix = af64 + alu_res;
    if (a_fix > FX360) begin
      a_fix = a_fix - FX360;
    end else if (a_fix < 64'sd0) begin
      a_fix = a_fix + FX360;
    end
    sum   = x_r + alu_res;
    pabs  = (x_r < 64'sd0) ? -x_r : x_r;
    mag64 = pabs >>> FRAC_BITS;

    if (state_r == S_IDLE && in_valid) begin
      pos_nxt = in_encoder_position;
      off_nxt = phase_r;
    end

    if (alu_done) begin
      case (state_r)
        S_DEG, S_AMUL, S_VMUL, S_UMUL, S_EWDIV, S_ATMUL2, S_P1MUL, S_P2MUL,
        S_P3MUL: begin
          t_nxt = alu_res;
        end
        S_ADIV: af_nxt = sat32(a_fix);
        S_VDIV: begin
          v_nxt  = sat32(v64 + alu_res);
          ap_nxt = af_r;
        end
        S_UDIV: begin
          u_nxt    = sat32(u64 + alu_res);
          rp_nxt   = v_r;
          x_nxt    = err_now;
          wneg_nxt = wrap_lo;
        end
        S_EWMUL: begin
          x_nxt = wneg_r ? x_r + (alu_res <<< FRAC_BITS) : x_r - (alu_res <<< FRAC_BITS);
        end
        S_RTMUL: begin
          if (alu_res > vl_fx) begin
            rt_nxt = vl_fx;
          end else if (alu_res < -vl_fx) begin
            rt_nxt = -vl_fx;
          end else begin
            rt_nxt = alu_res;
          end
        end
        S_ATMUL1: t_nxt = alu_res - at64;
        S_ATDIV: begin
          at_nxt  = sat32(at64 + alu_res);
          rtp_nxt = sat32(rt_r);
        end
        S_P1DIV: x_nxt = alu_res;
        S_P2DIV: x_nxt = sum;
        S_P3DIV: begin
          // pulse clamp
          if (sum > plim_fx) begin
            x_nxt = plim_fx;
          end else if (sum < -plim_fx) begin
            x_nxt = -plim_fx;
          end else begin
            x_nxt = sum;
          end
        end
        default: t_nxt = t_r;
      endcase
    end

    if (out_fire) begin
      out_valid_nxt = 1'b1;
      angle_nxt     = af_r;
      if (off_r) begin
        dir_nxt    = DIR_OFF;
        reload_nxt = OFF_RELOAD;
        pcmd_nxt   = '0;
        phase_nxt  = 1'b0;
      end else begin
        pcmd_nxt = (x_r < 64'sd0) ? -signed'(mag64[14:0]) : signed'(mag64[14:0]);
        if (x_r > db_fx) begin
          dir_nxt    = DIR_POS;
          reload_nxt = 16'hFFFF - mag64[15:0];
          phase_nxt  = 1'b1;
        end else if (x_r < -db_fx) begin
          dir_nxt    = DIR_NEG;
          reload_nxt = 16'hFFFF - mag64[15:0];
          phase_nxt  = 1'b1;
        end else begin
          // inside the deadband: no reload, stay in drive phase
          dir_nxt    = DIR_OFF;
          reload_nxt = 16'h0000;
          phase_nxt  = 1'b0;
        end
      end
    end
  end

  // control, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      af_r        <= '0;
      ap_r        <= '0;
      v_r         <= '0;
      rp_r        <= '0;
      u_r         <= '0;
      rtp_r       <= '0;
      at_r        <= '0;
      tgt_r       <= RST_TARGET;
      gain_r      <= RST_GAIN;
      vl_r        <= RST_RATE_LIM;
      us_r        <= RST_ACCEL_SC;
      plim_r      <= RST_PULSE_LIM;
      db_r        <= RST_DEADBAND;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      af_r        <= af_nxt;
      ap_r        <= ap_nxt;
      v_r         <= v_nxt;
      rp_r        <= rp_nxt;
      u_r         <= u_nxt;
      rtp_r       <= rtp_nxt;
      at_r        <= at_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET:    tgt_r  <= cfg_data[8:0];
          REG_GAIN:      gain_r <= cfg_data[13:0];
          REG_RATE_LIM:  vl_r   <= cfg_data[9:0];
          REG_ACCEL_SC:  us_r   <= cfg_data[6:0];
          REG_PULSE_LIM: plim_r <= cfg_data[13:0];
          REG_DEADBAND:  db_r   <= cfg_data[13:0];
          default:       tgt_r  <= tgt_r;
        endcase
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    off_r    <= off_nxt;
    wneg_r   <= wneg_nxt;
    t_r      <= t_nxt;
    x_r      <= x_nxt;
    rt_r     <= rt_nxt;
    dir_r    <= dir_nxt;
    reload_r <= reload_nxt;
    pcmd_r   <= pcmd_nxt;
    angle_r  <= angle_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_drive_direction = dir_r;
  assign out_timer_reload    = reload_r;
  assign out_pulse_command   = pcmd_r;
  assign out_filtered_angle  = angle_r;

`ifndef SYNTHESIS
  // no operation outstanding while waiting for a tick
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !issued_r) else $error("operation pending in idle");
  // the unit only completes work that the sequencer issued
  a_done_issued: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> issued_r) else $error("unit done without request");
  // an accepted tick always leaves idle
  a_accept_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != S_IDLE) else $error("tick dropped");
`endif

endmodule

>>> tb/antenna_servo_pulse_drive_unit_tb.sv
`timescale 1ns / 1ps

module antenna_servo_pulse_drive_unit_tb;
  import aspd_pkg::*;

  localparam int  POS_W    = DEFAULT_ENCODER_BITS;
  localparam int  FRAC     = DEFAULT_FRAC_BITS;
  localparam int  POS_MAX  = (1 << POS_W) - 1;
  localparam int  STALL_LIMIT = 5000;
  localparam longint FX1   = longint'(1) << FRAC;

  typedef struct {
    drive_dir_t         dir;
    logic [15:0]        reload;
    logic signed [14:0] pulse;
    logic signed [31:0] angle;
  } drive_word_t;

  // directed row: encoder reading, and a typed result where it is obvious
  typedef struct {
    logic [POS_W-1:0] pos;
    bit               typed;
    drive_word_t      res;
  } tick_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [POS_W-1:0] in_encoder_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_drive_direction;
  logic [15:0] out_timer_reload;
  logic signed [14:0] out_pulse_command;
  logic signed [31:0] out_filtered_angle;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  antenna_servo_pulse_drive_unit i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_encoder_position (in_encoder_position),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_drive_direction (out_drive_direction),
    .out_timer_reload    (out_timer_reload),
    .out_pulse_command   (out_pulse_command),
    .out_filtered_angle  (out_filtered_angle),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mirror of the configuration registers
  logic [8:0]  tgt_deg;
  logic [13:0] gain_h;
  logic [9:0]  rate_lim;
  logic [6:0]  accel_sc;
  logic [13:0] pulse_lim;
  logic [13:0] dead_band;

  // mirror of the servo state
  int ang_filt, ang_prev, rate_est, rate_prev, acc_est, rt_prev, acc_tgt;
  bit off_next;

  drive_word_t servo_words[$];   // results still to come, oldest first
  int errors = 0;
  int src_idle = 13;
  int dst_idle = 63;
  int quiet_cycles = 0;

  function automatic int sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return int'(x);
  endfunction

  function automatic longint gain_of(longint x);
    return (x * longint'(gain_h)) / 100;
  endfunction

  // shorter way across the 0/360 seam
  function automatic longint seam_step(longint to_a, longint from_a);
    if (from_a > 270 * FX1 && to_a < 90 * FX1) return to_a + 360 * FX1 - from_a;
    if (to_a > 270 * FX1 && from_a < 90 * FX1) return to_a - from_a - 360 * FX1;
    return to_a - from_a;
  endfunction

  function automatic void servo_reset_state();
    tgt_deg = RST_TARGET; gain_h = RST_GAIN; rate_lim = RST_RATE_LIM;
    accel_sc = RST_ACCEL_SC; pulse_lim = RST_PULSE_LIM; dead_band = RST_DEADBAND;
    ang_filt = 0; ang_prev = 0; rate_est = 0; rate_prev = 0;
    acc_est = 0; rt_prev = 0; acc_tgt = 0; off_next = 0;
  endfunction

  // one tick of the servo: advances the mirrored state, returns the result word
  function automatic drive_word_t servo_tick(logic [POS_W-1:0] pos);
    drive_word_t r;
    longint deg, a, v, u, err, rt, at, pulse, plim, mag, vl, us, p, tgt;
    vl  = (rate_lim == 0) ? 1 : longint'(rate_lim);
    us  = (accel_sc == 0) ? 1 : longint'(accel_sc);
    p   = longint'(pulse_lim);
    tgt = longint'(tgt_deg) * FX1;
    if (off_next) begin
      off_next = 0;
      r.dir = DIR_OFF; r.reload = OFF_RELOAD; r.pulse = '0; r.angle = ang_filt;
      return r;
    end
    deg = ((longint'(pos) * 360 * FX1) + POS_MAX / 2) / POS_MAX;

    a = longint'(ang_filt);
    a = a + gain_of(seam_step(deg, a));
    if (a > 360 * FX1) a -= 360 * FX1;
    else if (a < 0) a += 360 * FX1;
    ang_filt = sat32(a);
    a = ang_filt;

    v = longint'(rate_est);
    v = v + gain_of(seam_step(a, longint'(ang_prev)) - v);
    rate_est = sat32(v);
    v = rate_est;
    ang_prev = ang_filt;

    u = longint'(acc_est);
    u = u + gain_of((v - longint'(rate_prev)) - u);
    acc_est = sat32(u);
    u = acc_est;
    rate_prev = rate_est;

    // target error folded into +-180 degrees
    err = tgt - a;
    if (err > 180 * FX1) err -= ((err - 180 * FX1 + 360 * FX1 - 1) / (360 * FX1)) * 360 * FX1;
    if (err < -180 * FX1) err += ((-180 * FX1 - err + 360 * FX1 - 1) / (360 * FX1)) * 360 * FX1;

    rt = 50 * err;
    if (rt > vl * FX1) rt = vl * FX1;
    else if (rt < -vl * FX1) rt = -vl * FX1;

    at = longint'(acc_tgt);
    at = at + gain_of((rt - longint'(rt_prev)) * 1000 - at);
    acc_tgt = sat32(at);
    at = acc_tgt;
    rt_prev = sat32(rt);

    pulse = ((at - u) * p) / us + ((rt - v) * p) / (2 * vl) + ((tgt - a) * p) / 1800;
    plim = p * FX1;
    if (pulse > plim) pulse = plim;
    if (pulse < -plim) pulse = -plim;

    mag = (pulse < 0 ? -pulse : pulse) / FX1;
    r.dir = DIR_OFF;
    r.reload = '0;
    if (pulse > longint'(dead_band) * FX1) begin
      r.dir = DIR_POS; r.reload = 16'(65535 - mag); off_next = 1;
    end else if (pulse < -longint'(dead_band) * FX1) begin
      r.dir = DIR_NEG; r.reload = 16'(65535 - mag); off_next = 1;
    end
    r.pulse = 15'(pulse / FX1);
    r.angle = ang_filt;
    return r;
  endfunction

  // present one tick; the expectation is queued at the accepting edge
  task automatic send_tick(input logic [POS_W-1:0] pos, input bit typed,
                           input drive_word_t typed_res);
    drive_word_t w;
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_encoder_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    w = servo_tick(pos);
    servo_words.push_back(typed ? typed_res : w);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (servo_words.size() != 0) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input cfg_reg_t idx, input int val);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET:    tgt_deg   = d[8:0];
      REG_GAIN:      gain_h    = d[13:0];
      REG_RATE_LIM:  rate_lim  = d[9:0];
      REG_ACCEL_SC:  accel_sc  = d[6:0];
      REG_PULSE_LIM: pulse_lim = d[13:0];
      REG_DEADBAND:  dead_band = d[13:0];
      default:       ;
    endcase
  endtask

  // result side: check each word against the oldest expectation, random stalls
  always @(posedge clk) begin
    drive_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (servo_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = servo_words.pop_front();
        if (out_drive_direction !== e.dir) begin
          $error("drive_direction: expected %0d, got %0d", e.dir, out_drive_direction);
          errors++;
        end
        if (out_timer_reload !== e.reload) begin
          $error("timer_reload: expected %h, got %h", e.reload, out_timer_reload);
          errors++;
        end
        if (out_pulse_command !== e.pulse) begin
          $error("pulse_command: expected %0d, got %0d", e.pulse, out_pulse_command);
          errors++;
        end
        if (out_filtered_angle !== e.angle) begin
          $error("filtered_angle: expected %0d, got %0d", e.angle, out_filtered_angle);
          errors++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= dst_idle);
  end

  // watchdog: too long with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // directed ticks under reset configuration: fresh state gives all zeros
  localparam drive_word_t ZERO_WORD = '{DIR_OFF, 16'h0000, 15'sd0, 32'sd0};
  tick_row_t dir_rows[] = '{
    '{12'd0,    1'b1, ZERO_WORD},
    '{12'd0,    1'b1, ZERO_WORD},
    '{12'd4095, 1'b0, ZERO_WORD},
    '{12'd4095, 1'b0, ZERO_WORD},
    '{12'd1,    1'b0, ZERO_WORD},
    '{12'd2048, 1'b0, ZERO_WORD},
    '{12'd2048, 1'b0, ZERO_WORD},
    '{12'd1024, 1'b0, ZERO_WORD},
    '{12'd3072, 1'b0, ZERO_WORD},
    '{12'd4094, 1'b0, ZERO_WORD},
    '{12'd5,    1'b0, ZERO_WORD},
    '{12'd4090, 1'b0, ZERO_WORD},
    '{12'd2730, 1'b0, ZERO_WORD},
    '{12'd3000, 1'b0, ZERO_WORD},
    '{12'd3500, 1'b0, ZERO_WORD},
    '{12'd4000, 1'b0, ZERO_WORD},
    '{12'd100,  1'b0, ZERO_WORD},
    '{12'd2047, 1'b0, ZERO_WORD},
    '{12'd1365, 1'b0, ZERO_WORD},
    '{12'd1,    1'b0, ZERO_WORD}
  };

  // register sets: target, gain, rate limit, accel scale, pulse limit, deadband
  int reg_sets[8][6] = '{
    '{90,  100,   200,  2,   6125,  512},
    '{360, 16383, 1000, 100, 16383, 16383},
    '{0,   0,     1,    1,   1,     0},
    '{180, 50,    0,    0,   8000,  100},
    '{270, 200,   500,  10,  3000,  50},
    '{45,  1000,  100,  50,  12000, 1000},
    '{359, 75,    1000, 1,   16383, 0},
    '{300, 100,   200,  2,   6125,  512}
  };

  initial begin
    int walk;
    int n;
    logic [POS_W-1:0] pos;
    servo_reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_tick(dir_rows[i].pos, dir_rows[i].typed, dir_rows[i].res);
    drain_results();

    n = 0;
    walk = $urandom_range(POS_MAX);
    for (int s = 0; s < 8; s++) begin
      drain_results();
      for (int r = 0; r < 6; r++) write_reg(cfg_reg_t'(r), reg_sets[s][r]);
      cfg_valid <= 1'b0;
      for (int k = 0; k < 250; k++) begin
        // idling pattern moves on by thirds of the run
        if (n < 667) begin src_idle = 13; dst_idle = 63; end
        else if (n < 1334) begin src_idle = 63; dst_idle = 13; end
        else begin src_idle = 0; dst_idle = 0; end
        // mostly a slow random walk so the filters settle, seam crossings included
        if ($urandom_range(99) < 70)
          walk = (walk + $urandom_range(80) - 40 + 4096) % 4096;
        else
          walk = $urandom_range(POS_MAX);
        pos = POS_W'(walk);
        send_tick(pos, 1'b0, ZERO_WORD);
        if ($urandom_range(99) == 0) drain_results();
        n++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/aspd_pkg.sv
hw/rtl/aspd_alu.sv
hw/rtl/antenna_servo_pulse_drive_unit.sv
tb/antenna_servo_pulse_drive_unit_tb.sv
